### rtl/sfd_pkg.sv
// Package for the SLIP frame decoder: byte codes, register indexes, status codes,
// the queue entry type passed from the front end to the result stage, reset constants.
// No dependencies.
package sfd_pkg;

    localparam logic [7:0] BYTE_FEND  = 8'hC0;
    localparam logic [7:0] BYTE_FESC  = 8'hDB;
    localparam logic [7:0] BYTE_TFEND = 8'hDC;
    localparam logic [7:0] BYTE_TFESC = 8'hDD;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_CAPACITY = 2'd2;

    localparam logic [15:0] RESET_SIZE_LIMIT      = 16'd4096;
    localparam logic [15:0] RESET_OUTPUT_CAPACITY = 16'd8192;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_BAD_ESCAPE = 2'd2,
        ST_TOO_LONG   = 2'd3
    } t_status;

    typedef struct packed {
        logic        has_data;
        logic [7:0]  data;
        logic        is_last;
        t_status     code;
        logic [15:0] length;
        logic [31:0] bytes_total;
        logic [31:0] packets_total;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_queue_head;

endpackage

### rtl/sfd_front.sv
// Front end of the SLIP frame decoder: accepts raw bytes, tracks escape and frame state,
// keeps the running counters and pushes data/status transactions into the queue.
// Depends on sfd_pkg.
module sfd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_raw_byte,
    input  logic             i_buffer_end,
    input  logic             i_escape_enable,
    input  logic [15:0]      i_size_limit,
    input  logic [15:0]      i_output_capacity,
    input  logic             i_queue_full,
    output logic             o_push,
    output sfd_pkg::t_entry  o_entry
);
    import sfd_pkg::*;

    logic        r_at_start;
    logic        r_esc_pending;
    logic        r_closed;
    t_status     r_error;
    logic [15:0] r_count;
    logic [31:0] r_bytes;
    logic [31:0] r_packets;

    logic        n_esc_pending;
    logic        n_closed;
    t_status     n_error;
    logic [15:0] n_count;
    logic        active;
    logic        have_data;
    logic [7:0]  data;
    t_status     code;
    logic        accept;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_esc_pending = r_esc_pending;
        n_closed      = r_closed;
        n_error       = r_error;
        have_data     = 1'b0;
        data          = i_raw_byte;
        active = !r_closed && (r_error == ST_OK) && (r_count < i_output_capacity);
        if (active) begin
            if (r_esc_pending) begin
                n_esc_pending = 1'b0;
                if (i_raw_byte == BYTE_TFEND) begin
                    have_data = 1'b1;
                    data      = BYTE_FEND;
                end else if (i_raw_byte == BYTE_TFESC) begin
                    have_data = 1'b1;
                    data      = BYTE_FESC;
                end else begin
                    n_error = ST_BAD_ESCAPE;
                end
            end else if (i_raw_byte == BYTE_FEND) begin
                if (!r_at_start) begin
                    n_closed = 1'b1;
                end
            end else if (i_escape_enable && i_raw_byte == BYTE_FESC) begin
                if (i_buffer_end) begin
                    n_error = ST_INCOMPLETE;
                end else begin
                    n_esc_pending = 1'b1;
                end
            end else begin
                have_data = 1'b1;
            end
        end
        n_count = have_data ? 16'(r_count + 16'd1) : r_count;
        code = n_error;
        if (code == ST_OK && n_count > i_size_limit) begin
            code = ST_TOO_LONG;
        end

        o_push                 = accept && (have_data || i_buffer_end);
        o_entry.has_data       = have_data;
        o_entry.data           = data;
        o_entry.is_last        = i_buffer_end;
        o_entry.code           = code;
        o_entry.length         = (code == ST_OK) ? n_count : 16'd0;
        o_entry.bytes_total    = (code == ST_OK) ? 32'(r_bytes + {16'd0, n_count}) : r_bytes;
        o_entry.packets_total  = (code == ST_OK) ? 32'(r_packets + 32'd1) : r_packets;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start    <= 1'b1;
            r_esc_pending <= 1'b0;
            r_closed      <= 1'b0;
            r_error       <= ST_OK;
            r_count       <= 16'd0;
            r_bytes       <= 32'd0;
            r_packets     <= 32'd0;
        end else if (accept) begin
            if (i_buffer_end) begin
                r_at_start    <= 1'b1;
                r_esc_pending <= 1'b0;
                r_closed      <= 1'b0;
                r_error       <= ST_OK;
                r_count       <= 16'd0;
                r_bytes       <= o_entry.bytes_total;
                r_packets     <= o_entry.packets_total;
            end else begin
                r_at_start    <= 1'b0;
                r_esc_pending <= n_esc_pending;
                r_closed      <= n_closed;
                r_error       <= n_error;
                r_count       <= n_count;
            end
        end
    end

endmodule

### rtl/sfd_queue.sv
// Short queue between the front end and the result stage of the SLIP frame decoder.
// Depends on sfd_pkg.
module sfd_queue #(
    parameter int Depth = sfd_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sfd_pkg::t_entry      i_entry,
    output logic                 o_full,
    input  logic                 i_pop,
    output sfd_pkg::t_queue_head o_head
);
    import sfd_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    t_entry              r_mem [Depth];
    logic [PtrW-1:0]     r_wr_ptr;
    logic [PtrW-1:0]     r_rd_ptr;
    logic [CntW-1:0]     r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full       = (r_count == CntW'(Depth));
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    function automatic logic [PtrW-1:0] f_next(input logic [PtrW-1:0] ptr);
        return (ptr == PtrW'(Depth - 1)) ? '0 : PtrW'(ptr + 1'b1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= CntW'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CntW'(r_count - 1'b1);
            end
        end
    end

endmodule

### rtl/sfd_back.sv
// Result stage of the SLIP frame decoder: turns each queue entry into a data result,
// a status result, or both, held in an output register. Depends on sfd_pkg.
module sfd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sfd_pkg::t_queue_head i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_is_status,
    output logic [7:0]           o_data_out,
    output logic [1:0]           o_status_code,
    output logic [15:0]          o_packet_length,
    output logic [31:0]          o_bytes_total,
    output logic [31:0]          o_packets_total,
    output logic                 o_last_of_run
);
    import sfd_pkg::*;

    logic        r_valid;
    logic        r_data_done;
    logic        r_is_status;
    logic [7:0]  r_data;
    t_status     r_code;
    logic [15:0] r_length;
    logic [31:0] r_bytes;
    logic [31:0] r_packets;
    logic        r_last;

    logic        load;
    logic        send_data;
    logic        n_data_done;

    assign load      = !r_valid || i_ready;
    assign send_data = i_head.entry.has_data && !r_data_done;

    always_comb begin
        o_pop       = 1'b0;
        n_data_done = r_data_done;
        if (load && i_head.valid) begin
            if (send_data) begin
                // hold the entry for its status when the byte also ends the buffer
                o_pop       = !i_head.entry.is_last;
                n_data_done = i_head.entry.is_last;
            end else begin
                o_pop       = 1'b1;
                n_data_done = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_data_done <= 1'b0;
        end else begin
            r_data_done <= n_data_done;
            if (load) begin
                r_valid <= i_head.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head.valid) begin
            if (send_data) begin
                r_is_status <= 1'b0;
                r_data      <= i_head.entry.data;
                r_code      <= ST_OK;
                r_length    <= 16'd0;
                r_bytes     <= 32'd0;
                r_packets   <= 32'd0;
                r_last      <= !i_head.entry.is_last;
            end else begin
                r_is_status <= 1'b1;
                r_data      <= 8'd0;
                r_code      <= i_head.entry.code;
                r_length    <= i_head.entry.length;
                r_bytes     <= i_head.entry.bytes_total;
                r_packets   <= i_head.entry.packets_total;
                r_last      <= 1'b1;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_is_status     = r_is_status;
    assign o_data_out      = r_data;
    assign o_status_code   = r_code;
    assign o_packet_length = r_length;
    assign o_bytes_total   = r_bytes;
    assign o_packets_total = r_packets;
    assign o_last_of_run   = r_last;

endmodule

### rtl/slip_frame_decoder.sv
// SLIP frame decoder top level: configuration registers, front end, queue, result stage.
// Depends on sfd_pkg, sfd_front, sfd_queue, sfd_back.
//
// Input channel: i_valid/o_ready carry one raw byte and a buffer_end flag per transaction.
// Output channel: o_valid/i_ready carry one result per transaction: a decoded byte
// (o_is_status = 0) or the end-of-buffer status with code, length and running counters.
// A byte causes zero, one or two results; last_of_run marks the final one.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 escape_enable, 1 size limit, 2 output_capacity); unknown indexes are ignored.
// Each result is registered in the queue and then in the output register.
// Throughput: one byte per cycle while o_ready is high; a byte that carries both a data
// byte and a status occupies the result register for the two results in turn.
// A QueueDepth-entry queue parts the front end from the result stage, so bytes keep
// flowing while the receiver stalls until the queue fills; then o_ready drops.
// Reset (synchronous, active low) empties the queue, clears counters and per-buffer
// state, and restores the register defaults.
module slip_frame_decoder #(
    parameter int QueueDepth = sfd_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_raw_byte,
    input  logic                            i_buffer_end,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_is_status,
    output logic [7:0]                      o_data_out,
    output logic [1:0]                      o_status_code,
    output logic [15:0]                     o_packet_length,
    output logic [31:0]                     o_bytes_total,
    output logic [31:0]                     o_packets_total,
    output logic                            o_last_of_run,
    input  logic                            i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sfd_pkg::*;

    logic        r_escape_enable;
    logic [15:0] r_size_limit;
    logic [15:0] r_output_capacity;

    logic        queue_full;
    logic        push;
    logic        pop;
    t_entry      entry;
    t_queue_head head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_enable   <= 1'b1;
            r_size_limit      <= RESET_SIZE_LIMIT;
            r_output_capacity <= RESET_OUTPUT_CAPACITY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ESCAPE_ENABLE:   r_escape_enable   <= i_cfg_data[0];
                CFG_SIZE_LIMIT:      r_size_limit      <= i_cfg_data;
                CFG_OUTPUT_CAPACITY: r_output_capacity <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sfd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_raw_byte        (i_raw_byte),
        .i_buffer_end      (i_buffer_end),
        .i_escape_enable   (r_escape_enable),
        .i_size_limit      (r_size_limit),
        .i_output_capacity (r_output_capacity),
        .i_queue_full      (queue_full),
        .o_push            (push),
        .o_entry           (entry)
    );

    sfd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_head  (head)
    );

    sfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_is_status     (o_is_status),
        .o_data_out      (o_data_out),
        .o_status_code   (o_status_code),
        .o_packet_length (o_packet_length),
        .o_bytes_total   (o_bytes_total),
        .o_packets_total (o_packets_total),
        .o_last_of_run   (o_last_of_run)
    );

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_status |-> o_last_of_run)
        else $error("status result without last_of_run");

    a_error_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_status && o_status_code != ST_OK |-> o_packet_length == 16'd0)
        else $error("error status carries a packet length");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !queue_full)
        else $error("queue push while full");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule
